### src/ldu_pkg.sv
// Shared types and constants for the CPU load instruction unit.
package ldu_pkg;

    typedef enum logic [3:0] {
        ACT_LD_R_R     = 4'd0,
        ACT_LD_RR_N16  = 4'd1,
        ACT_LD_A_RR    = 4'd2,
        ACT_ST_N16_A   = 4'd3,
        ACT_LD_A_N16   = 4'd4,
        ACT_ST_RR_A    = 4'd5,
        ACT_LD_R_N8    = 4'd6,
        ACT_STH_N8_A   = 4'd7,
        ACT_LDH_A_N8   = 4'd8,
        ACT_ST_N16_SP  = 4'd9,
        ACT_LD_SP_HL   = 4'd10,
        ACT_LD_HL_SPE  = 4'd11,
        ACT_LD_A_C     = 4'd12,
        ACT_ST_C_A     = 4'd13,
        ACT_READ_DATA  = 4'd14
    } t_action;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_INC  = 2'd1;
    localparam logic [1:0] STEP_DEC  = 2'd2;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    localparam logic [4:0] CYC_4  = 5'd4;
    localparam logic [4:0] CYC_8  = 5'd8;
    localparam logic [4:0] CYC_12 = 5'd12;
    localparam logic [4:0] CYC_16 = 5'd16;
    localparam logic [4:0] CYC_20 = 5'd20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        t_action     action;
        logic [2:0]  dest_reg;
        logic [2:0]  source_reg;
        logic [1:0]  pair;
        logic [1:0]  step_mode;
        logic [7:0]  imm8;
        logic [15:0] imm16;
        logic [7:0]  read_data;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_write_data;
        logic [4:0]  cycles;
        logic        last;
        logic [7:0]  reg_a_value;
        logic [15:0] reg_bc_value;
        logic [15:0] reg_de_value;
        logic [15:0] reg_hl_value;
        logic [15:0] stack_pointer;
        logic [3:0]  flag_bits;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [7:0]  a;
        logic [15:0] sp;
        logic [3:0]  flags;
        logic        read_pend;
        logic [2:0]  pend_target;
        logic [4:0]  pend_cycles;
    } t_regs;

endpackage

### src/cpu_load_instruction_unit_top.sv
// An item's first result is offered after the input register and the result queue.
// One item per cycle while the queue has room; the SP store yields two writes.
// The execute stage fires when the four-entry result queue has room for its results.
// Reset is synchronous and active low; it clears all registers and the queue.
// Top level of the load instruction unit: input register, execute, result queue.
module cpu_load_instruction_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ldu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ldu_pkg::t_out_item o_out_item
);

    logic                         r_in_valid;
    ldu_pkg::t_in_item            r_in;
    ldu_pkg::t_regs               r_regs;
    ldu_pkg::t_regs               n_regs;
    logic [1:0]                   w_res_cnt;
    ldu_pkg::t_out_item           w_res0;
    ldu_pkg::t_out_item           w_res1;
    logic [ldu_pkg::QCNT_W-1:0]   w_free;
    logic                         w_fire;
    logic [1:0]                   w_push_cnt;

    ldu_exec u_exec (
        .i_item    (r_in),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_res_cnt (w_res_cnt),
        .o_res0    (w_res0),
        .o_res1    (w_res1)
    );

    assign w_fire     = r_in_valid && (ldu_pkg::QCNT_W'(w_res_cnt) <= w_free);
    assign w_push_cnt = w_fire ? w_res_cnt : 2'd0;
    assign o_in_stall = r_in_valid && !w_fire;

    ldu_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_d0       (w_res0),
        .i_d1       (w_res1),
        .o_free     (w_free),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_regs     <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_regs <= n_regs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_free <= ldu_pkg::QCNT_W'(ldu_pkg::QDEPTH))
        else $error("Result queue holds more items than its depth.");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in))
        else $error("A waiting instruction was lost or changed.");

    a_read_sets_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res_cnt == 2'd1 && w_res0.kind == ldu_pkg::KIND_READ
        |=> r_regs.read_pend)
        else $error("A read request did not leave a read pending.");

    a_read_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == ldu_pkg::KIND_READ
        |-> o_out_item.last && o_out_item.cycles == 5'd0)
        else $error("A read request item carries a cycle count or is not last.");

endmodule

### src/ldu_exec.sv
// Combinational execution of one load instruction against the register state.
module ldu_exec (
    input  ldu_pkg::t_in_item  i_item,
    input  ldu_pkg::t_regs     i_regs,
    output ldu_pkg::t_regs     o_regs,
    output logic [1:0]         o_res_cnt,
    output ldu_pkg::t_out_item o_res0,
    output ldu_pkg::t_out_item o_res1
);

    function automatic logic [7:0] reg_read(ldu_pkg::t_regs r, logic [2:0] code);
        logic [7:0] v;
        unique case (code)
            ldu_pkg::REG_B:   v = r.b;
            ldu_pkg::REG_C:   v = r.c;
            ldu_pkg::REG_D:   v = r.d;
            ldu_pkg::REG_E:   v = r.e;
            ldu_pkg::REG_H:   v = r.h;
            ldu_pkg::REG_L:   v = r.l;
            ldu_pkg::REG_MEM: v = 8'h00;
            ldu_pkg::REG_A:   v = r.a;
        endcase
        return v;
    endfunction

    function automatic ldu_pkg::t_regs reg_write(ldu_pkg::t_regs r, logic [2:0] code,
                                                 logic [7:0] v);
        ldu_pkg::t_regs q;
        q = r;
        unique case (code)
            ldu_pkg::REG_B:   q.b = v;
            ldu_pkg::REG_C:   q.c = v;
            ldu_pkg::REG_D:   q.d = v;
            ldu_pkg::REG_E:   q.e = v;
            ldu_pkg::REG_H:   q.h = v;
            ldu_pkg::REG_L:   q.l = v;
            ldu_pkg::REG_MEM: q = r;
            ldu_pkg::REG_A:   q.a = v;
        endcase
        return q;
    endfunction

    logic [15:0] w_hl;
    logic [15:0] w_pair_val;
    logic [15:0] w_hl_stepped;
    logic [15:0] w_sp_sum;
    logic [4:0]  w_nib_sum;
    logic [8:0]  w_byte_sum;

    assign w_hl       = {i_regs.h, i_regs.l};
    assign w_sp_sum   = i_regs.sp + {{8{i_item.imm8[7]}}, i_item.imm8};
    assign w_nib_sum  = {1'b0, i_regs.sp[3:0]} + {1'b0, i_item.imm8[3:0]};
    assign w_byte_sum = {1'b0, i_regs.sp[7:0]} + {1'b0, i_item.imm8};

    always_comb begin
        unique case (i_item.pair)
            ldu_pkg::PAIR_BC: w_pair_val = {i_regs.b, i_regs.c};
            ldu_pkg::PAIR_DE: w_pair_val = {i_regs.d, i_regs.e};
            ldu_pkg::PAIR_HL: w_pair_val = w_hl;
            ldu_pkg::PAIR_SP: w_pair_val = i_regs.sp;
        endcase
    end

    always_comb begin
        w_hl_stepped = w_hl;
        if (i_item.pair == ldu_pkg::PAIR_HL) begin
            if (i_item.step_mode == ldu_pkg::STEP_INC) begin
                w_hl_stepped = w_hl + 16'd1;
            end else if (i_item.step_mode == ldu_pkg::STEP_DEC) begin
                w_hl_stepped = w_hl - 16'd1;
            end
        end
    end

    ldu_pkg::t_regs     regs;
    ldu_pkg::t_out_item r0;
    ldu_pkg::t_out_item r1;
    logic [1:0]         cnt;

    always_comb begin
        regs    = i_regs;
        r0      = '0;
        r1      = '0;
        r0.last = 1'b1;
        r1.last = 1'b1;
        cnt     = 2'd0;
        if (i_item.action <= ldu_pkg::ACT_ST_C_A) begin
            regs.read_pend = 1'b0;
        end
        unique case (i_item.action)
            ldu_pkg::ACT_LD_R_R: begin
                cnt = 2'd1;
                if (i_item.dest_reg == ldu_pkg::REG_MEM &&
                    i_item.source_reg == ldu_pkg::REG_MEM) begin
                    r0.cycles = ldu_pkg::CYC_4;
                end else if (i_item.source_reg == ldu_pkg::REG_MEM) begin
                    regs.read_pend   = 1'b1;
                    regs.pend_target = i_item.dest_reg;
                    regs.pend_cycles = ldu_pkg::CYC_8;
                    r0.kind          = ldu_pkg::KIND_READ;
                    r0.bus_address   = w_hl;
                end else if (i_item.dest_reg == ldu_pkg::REG_MEM) begin
                    r0.kind           = ldu_pkg::KIND_WRITE;
                    r0.bus_address    = w_hl;
                    r0.bus_write_data = reg_read(i_regs, i_item.source_reg);
                    r0.cycles         = ldu_pkg::CYC_8;
                end else begin
                    regs = reg_write(regs, i_item.dest_reg,
                                     reg_read(i_regs, i_item.source_reg));
                    r0.cycles = ldu_pkg::CYC_4;
                end
            end
            ldu_pkg::ACT_LD_RR_N16: begin
                unique case (i_item.pair)
                    ldu_pkg::PAIR_BC: {regs.b, regs.c} = i_item.imm16;
                    ldu_pkg::PAIR_DE: {regs.d, regs.e} = i_item.imm16;
                    ldu_pkg::PAIR_HL: {regs.h, regs.l} = i_item.imm16;
                    ldu_pkg::PAIR_SP: regs.sp = i_item.imm16;
                endcase
                r0.cycles = ldu_pkg::CYC_12;
                cnt       = 2'd1;
            end
            ldu_pkg::ACT_LD_A_RR: begin
                {regs.h, regs.l} = w_hl_stepped;
                regs.read_pend   = 1'b1;
                regs.pend_target = ldu_pkg::REG_A;
                regs.pend_cycles = ldu_pkg::CYC_8;
                r0.kind          = ldu_pkg::KIND_READ;
                r0.bus_address   = w_pair_val;
                cnt              = 2'd1;
            end
            ldu_pkg::ACT_ST_N16_A: begin
                r0.kind           = ldu_pkg::KIND_WRITE;
                r0.bus_address    = i_item.imm16;
                r0.bus_write_data = i_regs.a;
                r0.cycles         = ldu_pkg::CYC_12;
                cnt               = 2'd1;
            end
            ldu_pkg::ACT_LD_A_N16: begin
                regs.read_pend   = 1'b1;
                regs.pend_target = ldu_pkg::REG_A;
                regs.pend_cycles = ldu_pkg::CYC_16;
                r0.kind          = ldu_pkg::KIND_READ;
                r0.bus_address   = i_item.imm16;
                cnt              = 2'd1;
            end
            ldu_pkg::ACT_ST_RR_A: begin
                {regs.h, regs.l}  = w_hl_stepped;
                r0.kind           = ldu_pkg::KIND_WRITE;
                r0.bus_address    = w_pair_val;
                r0.bus_write_data = i_regs.a;
                r0.cycles         = ldu_pkg::CYC_8;
                cnt               = 2'd1;
            end
            ldu_pkg::ACT_LD_R_N8: begin
                if (i_item.dest_reg == ldu_pkg::REG_MEM) begin
                    r0.kind           = ldu_pkg::KIND_WRITE;
                    r0.bus_address    = w_hl;
                    r0.bus_write_data = i_item.imm8;
                    r0.cycles         = ldu_pkg::CYC_12;
                end else begin
                    regs      = reg_write(regs, i_item.dest_reg, i_item.imm8);
                    r0.cycles = ldu_pkg::CYC_8;
                end
                cnt = 2'd1;
            end
            ldu_pkg::ACT_STH_N8_A: begin
                r0.kind           = ldu_pkg::KIND_WRITE;
                r0.bus_address    = ldu_pkg::HIGH_PAGE | {8'h00, i_item.imm8};
                r0.bus_write_data = i_regs.a;
                r0.cycles         = ldu_pkg::CYC_12;
                cnt               = 2'd1;
            end
            ldu_pkg::ACT_LDH_A_N8: begin
                regs.read_pend   = 1'b1;
                regs.pend_target = ldu_pkg::REG_A;
                regs.pend_cycles = ldu_pkg::CYC_12;
                r0.kind          = ldu_pkg::KIND_READ;
                r0.bus_address   = ldu_pkg::HIGH_PAGE | {8'h00, i_item.imm8};
                cnt              = 2'd1;
            end
            ldu_pkg::ACT_ST_N16_SP: begin
                r0.kind           = ldu_pkg::KIND_WRITE;
                r0.bus_address    = i_item.imm16;
                r0.bus_write_data = i_regs.sp[7:0];
                r0.last           = 1'b0;
                r1.kind           = ldu_pkg::KIND_WRITE;
                r1.bus_address    = i_item.imm16 + 16'd1;
                r1.bus_write_data = i_regs.sp[15:8];
                r1.cycles         = ldu_pkg::CYC_20;
                cnt               = 2'd2;
            end
            ldu_pkg::ACT_LD_SP_HL: begin
                regs.sp   = w_hl;
                r0.cycles = ldu_pkg::CYC_8;
                cnt       = 2'd1;
            end
            ldu_pkg::ACT_LD_HL_SPE: begin
                {regs.h, regs.l} = w_sp_sum;
                regs.flags       = {2'b00, w_nib_sum[4], w_byte_sum[8]};
                r0.cycles        = ldu_pkg::CYC_12;
                cnt              = 2'd1;
            end
            ldu_pkg::ACT_LD_A_C: begin
                regs.read_pend   = 1'b1;
                regs.pend_target = ldu_pkg::REG_A;
                regs.pend_cycles = ldu_pkg::CYC_8;
                r0.kind          = ldu_pkg::KIND_READ;
                r0.bus_address   = ldu_pkg::HIGH_PAGE | {8'h00, i_regs.c};
                cnt              = 2'd1;
            end
            ldu_pkg::ACT_ST_C_A: begin
                r0.kind           = ldu_pkg::KIND_WRITE;
                r0.bus_address    = ldu_pkg::HIGH_PAGE | {8'h00, i_regs.c};
                r0.bus_write_data = i_regs.a;
                r0.cycles         = ldu_pkg::CYC_8;
                cnt               = 2'd1;
            end
            ldu_pkg::ACT_READ_DATA: begin
                if (i_regs.read_pend) begin
                    regs.read_pend = 1'b0;
                    regs      = reg_write(regs, i_regs.pend_target, i_item.read_data);
                    r0.cycles = i_regs.pend_cycles;
                    cnt       = 2'd1;
                end
            end
            default: begin
            end
        endcase

        r0.reg_a_value   = regs.a;
        r0.reg_bc_value  = {regs.b, regs.c};
        r0.reg_de_value  = {regs.d, regs.e};
        r0.reg_hl_value  = {regs.h, regs.l};
        r0.stack_pointer = regs.sp;
        r0.flag_bits     = regs.flags;
        r1.reg_a_value   = regs.a;
        r1.reg_bc_value  = {regs.b, regs.c};
        r1.reg_de_value  = {regs.d, regs.e};
        r1.reg_hl_value  = {regs.h, regs.l};
        r1.stack_pointer = regs.sp;
        r1.flag_bits     = regs.flags;
    end

    assign o_regs    = regs;
    assign o_res_cnt = cnt;
    assign o_res0    = r0;
    assign o_res1    = r1;

endmodule

### src/ldu_out_fifo.sv
// Result queue that takes up to two items a cycle and delivers one unless the output is stalled.
module ldu_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_cnt,
    input  ldu_pkg::t_out_item            i_d0,
    input  ldu_pkg::t_out_item            i_d1,
    output logic [ldu_pkg::QCNT_W-1:0]    o_free,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ldu_pkg::t_out_item            o_data
);

    ldu_pkg::t_out_item                r_mem [ldu_pkg::QDEPTH];
    logic [ldu_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [ldu_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [ldu_pkg::QCNT_W-1:0]        r_count;
    logic                              w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_free  = ldu_pkg::QCNT_W'(ldu_pkg::QDEPTH) - r_count;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ldu_pkg::QPTR_W'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + ldu_pkg::QPTR_W'(w_pop);
            r_count  <= r_count + ldu_pkg::QCNT_W'(i_push_cnt)
                        - ldu_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_d0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + ldu_pkg::QPTR_W'(1)] <= i_d1;
        end
    end

endmodule

### verif/cpu_load_instruction_unit_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the load instruction unit: directed and random instruction streams.
module cpu_load_instruction_unit_top_tb;

    localparam ldu_pkg::t_action ACT_UNUSED = ldu_pkg::t_action'(4'hF);
    localparam int RANDOM_ITEMS = 1150;
    localparam int TAIL_ITEMS = 120;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 20;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    ldu_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ldu_pkg::t_out_item o_out_item;

    cpu_load_instruction_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    ldu_pkg::t_in_item  queued_instructions [$];
    ldu_pkg::t_out_item expected_results [$];

    logic [7:0]  reg_file [8] = '{default: 8'h00};
    logic [15:0] stack_ptr = 16'h0000;
    logic [3:0]  flag_reg = 4'h0;
    bit          read_waiting = 1'b0;
    logic [2:0]  read_target = 3'd0;
    logic [4:0]  read_cycles = 5'd0;

    bit mismatch_seen = 1'b0;
    bit idle_window = 1'b1;
    bit quiet_tail = 1'b0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;

    function automatic logic [15:0] pair_value(logic [1:0] pr);
        case (pr)
            ldu_pkg::PAIR_BC: return {reg_file[ldu_pkg::REG_B], reg_file[ldu_pkg::REG_C]};
            ldu_pkg::PAIR_DE: return {reg_file[ldu_pkg::REG_D], reg_file[ldu_pkg::REG_E]};
            ldu_pkg::PAIR_HL: return {reg_file[ldu_pkg::REG_H], reg_file[ldu_pkg::REG_L]};
            default: return stack_ptr;
        endcase
    endfunction

    task automatic set_pair(logic [1:0] pr, logic [15:0] value);
        case (pr)
            ldu_pkg::PAIR_BC: {reg_file[ldu_pkg::REG_B], reg_file[ldu_pkg::REG_C]} = value;
            ldu_pkg::PAIR_DE: {reg_file[ldu_pkg::REG_D], reg_file[ldu_pkg::REG_E]} = value;
            ldu_pkg::PAIR_HL: {reg_file[ldu_pkg::REG_H], reg_file[ldu_pkg::REG_L]} = value;
            default: stack_ptr = value;
        endcase
    endtask

    task automatic step_hl(logic [1:0] pr, logic [1:0] mode);
        if (pr == ldu_pkg::PAIR_HL) begin
            if (mode == ldu_pkg::STEP_INC) begin
                set_pair(ldu_pkg::PAIR_HL, pair_value(ldu_pkg::PAIR_HL) + 16'd1);
            end else if (mode == ldu_pkg::STEP_DEC) begin
                set_pair(ldu_pkg::PAIR_HL, pair_value(ldu_pkg::PAIR_HL) - 16'd1);
            end
        end
    endtask

    function automatic ldu_pkg::t_out_item bus_result(ldu_pkg::t_kind kind,
                                                      logic [15:0] addr, logic [7:0] data,
                                                      logic [4:0] cyc, logic last_flag);
        ldu_pkg::t_out_item r;
        r = '0;
        r.kind = kind;
        r.bus_address = addr;
        r.bus_write_data = data;
        r.cycles = cyc;
        r.last = last_flag;
        return r;
    endfunction

    function automatic ldu_pkg::t_out_item issue_read(logic [15:0] addr, logic [2:0] target,
                                                      logic [4:0] cyc);
        read_waiting = 1'b1;
        read_target = target;
        read_cycles = cyc;
        return bus_result(ldu_pkg::KIND_READ, addr, 8'h00, 5'd0, 1'b1);
    endfunction

    // Updates the register state for one accepted item and queues the results it causes.
    task automatic execute_load(input ldu_pkg::t_in_item it);
        ldu_pkg::t_out_item res [2];
        int                 n;
        logic [15:0]        addr;
        logic [4:0]         nib_sum;
        logic [8:0]         byte_sum;
        n = 1;
        if (it.action == ldu_pkg::ACT_READ_DATA) begin
            if (!read_waiting) begin
                return;
            end
            read_waiting = 1'b0;
            if (read_target != ldu_pkg::REG_MEM) begin
                reg_file[read_target] = it.read_data;
            end
            res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00, read_cycles, 1'b1);
        end else if (it.action == ACT_UNUSED) begin
            return;
        end else begin
            read_waiting = 1'b0;
            case (it.action)
                ldu_pkg::ACT_LD_R_R: begin
                    if (it.dest_reg == ldu_pkg::REG_MEM &&
                        it.source_reg == ldu_pkg::REG_MEM) begin
                        res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                            ldu_pkg::CYC_4, 1'b1);
                    end else if (it.source_reg == ldu_pkg::REG_MEM) begin
                        res[0] = issue_read(pair_value(ldu_pkg::PAIR_HL), it.dest_reg,
                                            ldu_pkg::CYC_8);
                    end else if (it.dest_reg == ldu_pkg::REG_MEM) begin
                        res[0] = bus_result(ldu_pkg::KIND_WRITE, pair_value(ldu_pkg::PAIR_HL),
                                            reg_file[it.source_reg], ldu_pkg::CYC_8, 1'b1);
                    end else begin
                        reg_file[it.dest_reg] = reg_file[it.source_reg];
                        res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                            ldu_pkg::CYC_4, 1'b1);
                    end
                end
                ldu_pkg::ACT_LD_RR_N16: begin
                    set_pair(it.pair, it.imm16);
                    res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                        ldu_pkg::CYC_12, 1'b1);
                end
                ldu_pkg::ACT_LD_A_RR: begin
                    addr = pair_value(it.pair);
                    step_hl(it.pair, it.step_mode);
                    res[0] = issue_read(addr, ldu_pkg::REG_A, ldu_pkg::CYC_8);
                end
                ldu_pkg::ACT_ST_N16_A: begin
                    res[0] = bus_result(ldu_pkg::KIND_WRITE, it.imm16, reg_file[ldu_pkg::REG_A],
                                        ldu_pkg::CYC_12, 1'b1);
                end
                ldu_pkg::ACT_LD_A_N16: begin
                    res[0] = issue_read(it.imm16, ldu_pkg::REG_A, ldu_pkg::CYC_16);
                end
                ldu_pkg::ACT_ST_RR_A: begin
                    addr = pair_value(it.pair);
                    step_hl(it.pair, it.step_mode);
                    res[0] = bus_result(ldu_pkg::KIND_WRITE, addr, reg_file[ldu_pkg::REG_A],
                                        ldu_pkg::CYC_8, 1'b1);
                end
                ldu_pkg::ACT_LD_R_N8: begin
                    if (it.dest_reg == ldu_pkg::REG_MEM) begin
                        res[0] = bus_result(ldu_pkg::KIND_WRITE, pair_value(ldu_pkg::PAIR_HL),
                                            it.imm8, ldu_pkg::CYC_12, 1'b1);
                    end else begin
                        reg_file[it.dest_reg] = it.imm8;
                        res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                            ldu_pkg::CYC_8, 1'b1);
                    end
                end
                ldu_pkg::ACT_STH_N8_A: begin
                    res[0] = bus_result(ldu_pkg::KIND_WRITE,
                                        ldu_pkg::HIGH_PAGE + {8'h00, it.imm8},
                                        reg_file[ldu_pkg::REG_A], ldu_pkg::CYC_12, 1'b1);
                end
                ldu_pkg::ACT_LDH_A_N8: begin
                    res[0] = issue_read(ldu_pkg::HIGH_PAGE + {8'h00, it.imm8}, ldu_pkg::REG_A,
                                        ldu_pkg::CYC_12);
                end
                ldu_pkg::ACT_ST_N16_SP: begin
                    res[0] = bus_result(ldu_pkg::KIND_WRITE, it.imm16, stack_ptr[7:0], 5'd0,
                                        1'b0);
                    res[1] = bus_result(ldu_pkg::KIND_WRITE, it.imm16 + 16'd1, stack_ptr[15:8],
                                        ldu_pkg::CYC_20, 1'b1);
                    n = 2;
                end
                ldu_pkg::ACT_LD_SP_HL: begin
                    stack_ptr = pair_value(ldu_pkg::PAIR_HL);
                    res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                        ldu_pkg::CYC_8, 1'b1);
                end
                ldu_pkg::ACT_LD_HL_SPE: begin
                    nib_sum = {1'b0, stack_ptr[3:0]} + {1'b0, it.imm8[3:0]};
                    byte_sum = {1'b0, stack_ptr[7:0]} + {1'b0, it.imm8};
                    set_pair(ldu_pkg::PAIR_HL, stack_ptr + {{8{it.imm8[7]}}, it.imm8});
                    flag_reg = {2'b00, nib_sum[4], byte_sum[8]};
                    res[0] = bus_result(ldu_pkg::KIND_DONE, 16'h0000, 8'h00,
                                        ldu_pkg::CYC_12, 1'b1);
                end
                ldu_pkg::ACT_LD_A_C: begin
                    res[0] = issue_read(ldu_pkg::HIGH_PAGE + {8'h00, reg_file[ldu_pkg::REG_C]},
                                        ldu_pkg::REG_A, ldu_pkg::CYC_8);
                end
                default: begin
                    res[0] = bus_result(ldu_pkg::KIND_WRITE,
                                        ldu_pkg::HIGH_PAGE + {8'h00, reg_file[ldu_pkg::REG_C]},
                                        reg_file[ldu_pkg::REG_A], ldu_pkg::CYC_8, 1'b1);
                end
            endcase
        end
        for (int k = 0; k < n; k++) begin
            res[k].reg_a_value = reg_file[ldu_pkg::REG_A];
            res[k].reg_bc_value = pair_value(ldu_pkg::PAIR_BC);
            res[k].reg_de_value = pair_value(ldu_pkg::PAIR_DE);
            res[k].reg_hl_value = pair_value(ldu_pkg::PAIR_HL);
            res[k].stack_pointer = stack_ptr;
            res[k].flag_bits = flag_reg;
            expected_results.push_back(res[k]);
        end
    endtask

    task automatic queue_instr(ldu_pkg::t_action act, logic [2:0] dst, logic [2:0] src,
                               logic [1:0] pr, logic [1:0] mode, logic [7:0] b8,
                               logic [15:0] w16, logic [7:0] rd);
        ldu_pkg::t_in_item it;
        it.action = act;
        it.dest_reg = dst;
        it.source_reg = src;
        it.pair = pr;
        it.step_mode = mode;
        it.imm8 = b8;
        it.imm16 = w16;
        it.read_data = rd;
        queued_instructions.push_back(it);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 300 == 0) begin
            idle_window = $urandom_range(0, 3) != 0;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                execute_load(i_in_item);
            end
            if (queued_instructions.size() < TAIL_ITEMS) begin
                quiet_tail = 1'b1;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (queued_instructions.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_item <= queued_instructions.pop_front();
                if (idle_window && !quiet_tail && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 19);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        ldu_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time,
                             o_out_item);
                    mismatch_seen = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(o_out_item.kind));
                    check_field("bus_address", want.bus_address, o_out_item.bus_address);
                    check_field("bus_write_data", 16'(want.bus_write_data),
                                16'(o_out_item.bus_write_data));
                    check_field("cycles", 16'(want.cycles), 16'(o_out_item.cycles));
                    check_field("last", 16'(want.last), 16'(o_out_item.last));
                    check_field("reg_a_value", 16'(want.reg_a_value),
                                16'(o_out_item.reg_a_value));
                    check_field("reg_bc_value", want.reg_bc_value, o_out_item.reg_bc_value);
                    check_field("reg_de_value", want.reg_de_value, o_out_item.reg_de_value);
                    check_field("reg_hl_value", want.reg_hl_value, o_out_item.reg_hl_value);
                    check_field("stack_pointer", want.stack_pointer, o_out_item.stack_pointer);
                    check_field("flag_bits", 16'(want.flag_bits), 16'(o_out_item.flag_bits));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_window && !quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        ldu_pkg::t_action act;
        int               counted;
        int               pick;
        bit               reads_memory;

        i_rst_n = 1'b0;

        queue_instr(ldu_pkg::ACT_LD_RR_N16, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_SP,
                    ldu_pkg::STEP_NONE, 8'h00, 16'hFFFF, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_RR_N16, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_HL,
                    ldu_pkg::STEP_NONE, 8'h00, 16'hFFFF, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_A_RR, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_HL,
                    ldu_pkg::STEP_INC, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'hFF);
        queue_instr(ldu_pkg::ACT_LD_A_RR, ldu_pkg::REG_A, ldu_pkg::REG_A, ldu_pkg::PAIR_HL,
                    ldu_pkg::STEP_DEC, 8'hFF, 16'hFFFF, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_A_N16, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'hFFFF, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h5A);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_A, ldu_pkg::REG_A, ldu_pkg::PAIR_SP,
                    2'd3, 8'hFF, 16'hFFFF, 8'h33);
        queue_instr(ldu_pkg::ACT_ST_RR_A, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_INC, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_ST_RR_A, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_SP,
                    2'd3, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_A_RR, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_SP,
                    ldu_pkg::STEP_DEC, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_R_R, ldu_pkg::REG_MEM, ldu_pkg::REG_MEM, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_R_R, ldu_pkg::REG_B, ldu_pkg::REG_MEM, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h80);
        queue_instr(ldu_pkg::ACT_LD_R_R, ldu_pkg::REG_MEM, ldu_pkg::REG_A, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_R_N8, ldu_pkg::REG_C, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'hFF, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_R_N8, ldu_pkg::REG_MEM, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_STH_N8_A, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'hFF, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LDH_A_N8, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'hC3);
        queue_instr(ldu_pkg::ACT_ST_N16_SP, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'hFFFF, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_SP_HL, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_HL_SPE, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h80, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_HL_SPE, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h7F, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_LD_A_C, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ldu_pkg::ACT_READ_DATA, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h01);
        queue_instr(ldu_pkg::ACT_ST_C_A, ldu_pkg::REG_B, ldu_pkg::REG_B, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);
        queue_instr(ACT_UNUSED, ldu_pkg::REG_A, ldu_pkg::REG_A, ldu_pkg::PAIR_SP,
                    2'd3, 8'hFF, 16'hFFFF, 8'hFF);
        queue_instr(ldu_pkg::ACT_LD_R_R, ldu_pkg::REG_E, ldu_pkg::REG_A, ldu_pkg::PAIR_BC,
                    ldu_pkg::STEP_NONE, 8'h00, 16'h0000, 8'h00);

        // Mostly complete instructions; a read is usually answered, sometimes
        // superseded, and stray data and unused opcodes are mixed in as noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                act = ACT_UNUSED;
            end else if (pick < 8) begin
                act = ldu_pkg::ACT_READ_DATA;
            end else begin
                act = ldu_pkg::t_action'($urandom_range(0, 13));
                counted++;
            end
            queue_instr(act, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                        2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)));
            reads_memory = act inside {ldu_pkg::ACT_LD_A_RR, ldu_pkg::ACT_LD_A_N16,
                                       ldu_pkg::ACT_LDH_A_N8, ldu_pkg::ACT_LD_A_C};
            if (act == ldu_pkg::ACT_LD_R_R) begin
                reads_memory = queued_instructions[$].source_reg == ldu_pkg::REG_MEM &&
                               queued_instructions[$].dest_reg != ldu_pkg::REG_MEM;
            end
            if (reads_memory && $urandom_range(0, 9) != 0) begin
                queue_instr(ldu_pkg::ACT_READ_DATA, 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)),
                            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)));
                counted++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_instructions.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### cpu_load_instruction_unit_top.f
src/ldu_pkg.sv
src/ldu_exec.sv
src/ldu_out_fifo.sv
src/cpu_load_instruction_unit_top.sv
verif/cpu_load_instruction_unit_top_tb.sv
